>>> sv/sha1_pkg.sv
// Package with the types, constants and round functions shared by the SHA-1 core.
package sha1_pkg;

   typedef struct packed {
      logic       kind;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_type;

   typedef logic [4:0][31:0] chain_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COMPRESS,
      ST_UPDATE,
      ST_PAD,
      ST_LEN,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic shift;
      logic step;
   } sched_ctl_type;

   typedef struct packed {
      logic load;
      logic step;
   } round_ctl_type;

   localparam logic       KIND_BYTE = 1'b0;
   localparam logic       KIND_END  = 1'b1;
   localparam int         NUM_ROUNDS = 80;
   localparam int         NUM_WORDS  = 5;
   localparam logic [6:0] LAST_ROUND = 7'(NUM_ROUNDS - 1);
   localparam logic [2:0] LAST_WORD  = 3'(NUM_WORDS - 1);
   localparam logic [5:0] LEN_FILL   = 6'd56;
   localparam logic [5:0] FULL_FILL  = 6'd63;
   localparam logic [7:0] PAD_MARK   = 8'h80;

   localparam chain_type CHAIN_INIT = {
      32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
   };

   function automatic logic [31:0] round_k(input logic [6:0] rnd);
      logic [31:0] k;
      priority if (rnd < 7'd20) begin
         k = 32'h5A827999;
      end else if (rnd < 7'd40) begin
         k = 32'h6ED9EBA1;
      end else if (rnd < 7'd60) begin
         k = 32'h8F1BBCDC;
      end else begin
         k = 32'hCA62C1D6;
      end
      return k;
   endfunction

   function automatic logic [31:0] round_f(input logic [6:0] rnd, input logic [31:0] b,
                                           input logic [31:0] c, input logic [31:0] d);
      logic [31:0] f;
      priority if (rnd < 7'd20) begin
         f = (b & c) | (~b & d);
      end else if (rnd < 7'd40) begin
         f = b ^ c ^ d;
      end else if (rnd < 7'd60) begin
         f = (b & c) | (b & d) | (c & d);
      end else begin
         f = b ^ c ^ d;
      end
      return f;
   endfunction

endpackage

>>> sv/sha1_sched.sv
// Block buffer that gathers bytes and then serves as the sliding message schedule window.
module sha1_sched (
   input  logic                   clock,
   input  sha1_pkg::sched_ctl_type ctl,
   input  logic [7:0]             data_in,
   output logic [31:0]            w_out
);
   import sha1_pkg::*;

   logic [511:0] win_ff;
   logic [511:0] win_in;
   logic [31:0]  w_mix;
   logic [31:0]  w_new;

   // Word j of the window sits at bits [511-32j -: 32]; words 13, 8, 2 and 0 feed the next word.
   assign w_mix = win_ff[95:64] ^ win_ff[255:224] ^ win_ff[447:416] ^ win_ff[511:480];
   assign w_new = {w_mix[30:0], w_mix[31]};
   assign w_out = win_ff[511:480];

   always_comb begin
      priority if (ctl.shift) begin
         win_in = {win_ff[503:0], data_in};
      end else if (ctl.step) begin
         win_in = {win_ff[479:0], w_new};
      end else begin
         win_in = win_ff;
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
   end

endmodule

>>> sv/sha1_round.sv
// Shared SHA-1 round unit holding the working variables a through e.
module sha1_round (
   input  logic                    clock,
   input  sha1_pkg::round_ctl_type ctl,
   input  logic [6:0]              rnd,
   input  logic [31:0]             w_in,
   input  sha1_pkg::chain_type     chain,
   output sha1_pkg::chain_type     work
);
   import sha1_pkg::*;

   chain_type   work_ff;
   chain_type   work_in;
   logic [31:0] temp;

   assign temp = {work_ff[0][26:0], work_ff[0][31:27]}
               + round_f(rnd, work_ff[1], work_ff[2], work_ff[3])
               + work_ff[4] + round_k(rnd) + w_in;

   always_comb begin
      priority if (ctl.load) begin
         work_in = chain;
      end else if (ctl.step) begin
         work_in[0] = temp;
         work_in[1] = work_ff[0];
         work_in[2] = {work_ff[1][1:0], work_ff[1][31:2]};
         work_in[3] = work_ff[2];
         work_in[4] = work_ff[3];
      end else begin
         work_in = work_ff;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
   end

   assign work = work_ff;

endmodule

>>> sv/sha1_message_digest_core.sv
// Top level of the SHA-1 digest core: sequencer, chaining words, padding and digest output.
//
// Message bytes are taken one per cycle while the block buffer is not full. The transaction
// that fills the 64th byte of a block starts the compression, which runs one round per cycle
// on the shared round unit: req_stall stays high through the 80 rounds and the update step
// that adds the working variables into the chaining words. An end-of-message transaction
// shifts in the 0x80 mark, the zero padding and the 64-bit bit length one byte per cycle,
// runs one or two compressions, and then presents h0 to h4 as five rsp transactions, one per
// cycle when rsp_stall is low. After the last word the core returns to its initial state and
// takes the next message. There is no clearing pass after reset.
module sha1_message_digest_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  sha1_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output sha1_pkg::rsp_type rsp_data
);
   import sha1_pkg::*;

   state_type     state_ff;
   state_type     state_in;
   chain_type     chain_ff;
   chain_type     work;
   logic [5:0]    fill_ff;
   logic [60:0]   count_ff;
   logic [63:0]   len_ff;
   logic [6:0]    rnd_ff;
   logic [2:0]    idx_ff;
   logic          fin_ff;
   logic          len_done_ff;
   logic [31:0]   w_cur;
   logic [7:0]    shift_byte;
   sched_ctl_type sched_ctl;
   round_ctl_type round_ctl;
   logic          req_take;
   logic          rsp_take;
   logic          take_byte;
   logic          take_end;

   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = rsp_valid && !rsp_stall;
   assign take_byte = req_take && (req_data.kind == KIND_BYTE);
   assign take_end  = req_take && (req_data.kind == KIND_END);

   sha1_sched u_sched (
      .clock   (clock),
      .ctl     (sched_ctl),
      .data_in (shift_byte),
      .w_out   (w_cur)
   );

   sha1_round u_round (
      .clock (clock),
      .ctl   (round_ctl),
      .rnd   (rnd_ff),
      .w_in  (w_cur),
      .chain (chain_ff),
      .work  (work)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (fill_ff == FULL_FILL) begin
                  state_in = ST_COMPRESS;
               end else if (req_data.kind == KIND_END) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_COMPRESS: begin
            if (rnd_ff == LAST_ROUND) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            priority if (!fin_ff) begin
               state_in = ST_IDLE;
            end else if (len_done_ff) begin
               state_in = ST_OUT;
            end else begin
               state_in = ST_PAD;
            end
         end
         ST_PAD: begin
            priority if (fill_ff == LEN_FILL) begin
               state_in = ST_LEN;
            end else if (fill_ff == FULL_FILL) begin
               state_in = ST_COMPRESS;
            end else begin
               state_in = ST_PAD;
            end
         end
         ST_LEN: begin
            if (fill_ff == FULL_FILL) begin
               state_in = ST_COMPRESS;
            end
         end
         ST_OUT: begin
            if (!rsp_stall && idx_ff == LAST_WORD) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall       = 1'b1;
      rsp_valid       = 1'b0;
      sched_ctl.shift = 1'b0;
      sched_ctl.step  = 1'b0;
      round_ctl.load  = 1'b1;
      round_ctl.step  = 1'b0;
      shift_byte      = 8'd0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall       = 1'b0;
            sched_ctl.shift = req_valid;
            shift_byte      = (req_data.kind == KIND_END) ? PAD_MARK : req_data.data_byte;
         end
         ST_COMPRESS: begin
            sched_ctl.step = 1'b1;
            round_ctl.load = 1'b0;
            round_ctl.step = 1'b1;
         end
         ST_UPDATE: begin
            round_ctl.load = 1'b0;
         end
         ST_PAD: begin
            sched_ctl.shift = (fill_ff != LEN_FILL);
         end
         ST_LEN: begin
            sched_ctl.shift = 1'b1;
            shift_byte      = len_ff[63:56];
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         chain_ff    <= CHAIN_INIT;
         fill_ff     <= 6'd0;
         count_ff    <= 61'd0;
         rnd_ff      <= 7'd0;
         idx_ff      <= 3'd0;
         fin_ff      <= 1'b0;
         len_done_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (sched_ctl.shift) begin
            fill_ff <= fill_ff + 6'd1;
         end
         if (take_byte) begin
            count_ff <= count_ff + 61'd1;
         end
         if (take_end) begin
            fin_ff <= 1'b1;
         end
         if (state_ff == ST_LEN) begin
            len_done_ff <= 1'b1;
         end
         if (state_ff == ST_COMPRESS) begin
            rnd_ff <= (rnd_ff == LAST_ROUND) ? 7'd0 : rnd_ff + 7'd1;
         end
         if (state_ff == ST_UPDATE) begin
            for (int i = 0; i < NUM_WORDS; i++) begin
               chain_ff[i] <= chain_ff[i] + work[i];
            end
         end
         if (rsp_take) begin
            if (idx_ff == LAST_WORD) begin
               idx_ff      <= 3'd0;
               chain_ff    <= CHAIN_INIT;
               fill_ff     <= 6'd0;
               count_ff    <= 61'd0;
               fin_ff      <= 1'b0;
               len_done_ff <= 1'b0;
            end else begin
               idx_ff <= idx_ff + 3'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take_end) begin
         len_ff <= {count_ff, 3'b000};
      end else if (state_ff == ST_LEN) begin
         len_ff <= {len_ff[55:0], 8'd0};
      end
   end

   assign rsp_data.digest_word = chain_ff[idx_ff];
   assign rsp_data.word_index  = idx_ff;
   assign rsp_data.last_word   = (idx_ff == LAST_WORD);

   a_rnd_range: assert property (@(posedge clock) disable iff (reset)
      rnd_ff <= LAST_ROUND)
      else $error("round counter out of range");

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= LAST_WORD)
      else $error("digest word index out of range");

   a_rounds_end: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_COMPRESS && rnd_ff == LAST_ROUND |=> state_ff == ST_UPDATE)
      else $error("compression did not end after the last round");

   a_len_fill: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LEN |-> fill_ff >= LEN_FILL)
      else $error("length bytes written below their place in the block");

   a_restart: assert property (@(posedge clock) disable iff (reset)
      rsp_take && idx_ff == LAST_WORD |=> fill_ff == 6'd0 && count_ff == 61'd0 && !fin_ff)
      else $error("state not returned to initial values after the digest");

endmodule

>>> tb/sv/sha1_message_digest_core_tb.sv
// Self-checking testbench for the SHA-1 digest core with a built-in digest predictor.
module sha1_message_digest_core_tb;
   import sha1_pkg::*;

   typedef struct {
      req_type txn;
      bit      drain;
   } pending_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   pending_type message_stream_q[$];
   rsp_type     digest_expect_q[$];

   logic [31:0] hash_state [5];
   logic [7:0]  msg_block [64];
   int          block_fill;
   logic [60:0] byte_count;

   int          items_total = 0;
   int          items_accepted = 0;
   int          messages_done = 0;
   int          bytes_sent = 0;
   int          words_checked = 0;
   int          error_count = 0;
   int unsigned req_gap = 0;
   int unsigned rsp_hold = 0;
   bit          req_burst = 1'b0;
   bit          rsp_burst = 1'b0;

   sha1_message_digest_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic void restart_digest();
      hash_state[0] = 32'h67452301;
      hash_state[1] = 32'hEFCDAB89;
      hash_state[2] = 32'h98BADCFE;
      hash_state[3] = 32'h10325476;
      hash_state[4] = 32'hC3D2E1F0;
      block_fill = 0;
      byte_count = '0;
   endfunction

   function automatic void compress_block();
      logic [31:0] w [80];
      logic [31:0] a, b, c, d, e, f, k, t, x;
      for (int i = 0; i < 16; i++) begin
         w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
      end
      for (int i = 16; i < 80; i++) begin
         x = w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16];
         w[i] = {x[30:0], x[31]};
      end
      a = hash_state[0];
      b = hash_state[1];
      c = hash_state[2];
      d = hash_state[3];
      e = hash_state[4];
      for (int i = 0; i < 80; i++) begin
         if (i < 20) begin
            f = (b & c) | (~b & d);
            k = 32'h5A827999;
         end else if (i < 40) begin
            f = b ^ c ^ d;
            k = 32'h6ED9EBA1;
         end else if (i < 60) begin
            f = (b & c) | (b & d) | (c & d);
            k = 32'h8F1BBCDC;
         end else begin
            f = b ^ c ^ d;
            k = 32'hCA62C1D6;
         end
         t = {a[26:0], a[31:27]} + f + e + k + w[i];
         e = d;
         d = c;
         c = {b[1:0], b[31:2]};
         b = a;
         a = t;
      end
      hash_state[0] += a;
      hash_state[1] += b;
      hash_state[2] += c;
      hash_state[3] += d;
      hash_state[4] += e;
   endfunction

   function automatic void absorb_item(input req_type txn);
      logic [63:0] bit_len;
      rsp_type     word;
      int          pos;
      if (txn.kind == KIND_BYTE) begin
         msg_block[block_fill] = txn.data_byte;
         block_fill = (block_fill + 1) % 64;
         byte_count = byte_count + 1'b1;
         if (block_fill == 0) begin
            compress_block();
         end
      end else begin
         bit_len = {byte_count, 3'b000};
         msg_block[block_fill] = 8'h80;
         pos = block_fill + 1;
         if (pos > 56) begin
            while (pos < 64) begin
               msg_block[pos] = 8'h00;
               pos++;
            end
            compress_block();
            pos = 0;
         end
         while (pos < 56) begin
            msg_block[pos] = 8'h00;
            pos++;
         end
         for (int i = 0; i < 8; i++) begin
            msg_block[56+i] = bit_len[63-8*i -: 8];
         end
         compress_block();
         for (int i = 0; i < NUM_WORDS; i++) begin
            word.digest_word = hash_state[i];
            word.word_index  = 3'(i);
            word.last_word   = (i == NUM_WORDS - 1);
            digest_expect_q.insert(digest_expect_q.size(), word);
         end
         restart_digest();
      end
   endfunction

   task automatic queue_item(input logic kind, input logic [7:0] value, input bit drain);
      pending_type p;
      p.txn.kind      = kind;
      p.txn.data_byte = value;
      p.drain         = drain;
      message_stream_q.insert(message_stream_q.size(), p);
      items_total++;
   endtask

   task automatic queue_random_message(input int len, input bit drain);
      for (int i = 0; i < len; i++) begin
         queue_item(KIND_BYTE, 8'($urandom_range(0, 255)), drain && i == 0);
      end
      queue_item(KIND_END, 8'($urandom_range(0, 255)), drain && len == 0);
   endtask

   function automatic int unsigned draw_wait(input bit burst);
      return burst ? 0 : $urandom_range(0, 5);
   endfunction

   always @(posedge clock) begin : driver
      pending_type next_item;
      if (reset) begin
         req_valid <= 1'b0;
         req_gap <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            absorb_item(req_data);
            items_accepted++;
            if (req_data.kind == KIND_END) begin
               messages_done++;
            end else begin
               bytes_sent++;
            end
            if ($urandom_range(0, 39) == 0) begin
               req_burst <= !req_burst;
            end
         end
         if (!(req_valid && req_stall)) begin
            if (req_gap != 0) begin
               req_gap <= req_gap - 1;
               req_valid <= 1'b0;
            end else if (message_stream_q.size() != 0 &&
                         !(message_stream_q[0].drain && digest_expect_q.size() != 0)) begin
               next_item = message_stream_q.pop_front();
               req_data <= next_item.txn;
               req_valid <= 1'b1;
               req_gap <= draw_wait(req_burst);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : monitor
      rsp_type     want;
      int unsigned n;
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_hold <= 0;
      end else if (rsp_valid && !rsp_stall) begin
         words_checked++;
         if (digest_expect_q.size() == 0) begin
            $error("Unexpected digest word %h at index %0d", rsp_data.digest_word,
                   rsp_data.word_index);
            error_count++;
         end else begin
            want = digest_expect_q.pop_front();
            if (rsp_data.digest_word !== want.digest_word) begin
               $error("digest_word: expected %h, got %h", want.digest_word,
                      rsp_data.digest_word);
               error_count++;
            end
            if (rsp_data.word_index !== want.word_index) begin
               $error("word_index: expected %0d, got %0d", want.word_index,
                      rsp_data.word_index);
               error_count++;
            end
            if (rsp_data.last_word !== want.last_word) begin
               $error("last_word: expected %0b, got %0b", want.last_word,
                      rsp_data.last_word);
               error_count++;
            end
         end
         if ($urandom_range(0, 39) == 0) begin
            rsp_burst <= !rsp_burst;
         end
         n = draw_wait(rsp_burst);
         rsp_stall <= (n != 0);
         rsp_hold <= (n != 0) ? n - 1 : 0;
      end else if (rsp_stall) begin
         if (rsp_hold == 0) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_hold <= rsp_hold - 1;
         end
      end else if (!rsp_burst && $urandom_range(0, 7) == 0) begin
         rsp_stall <= 1'b1;
         rsp_hold <= $urandom_range(0, 4);
      end
   end

   initial begin
      int wait_cycles;
      int len;
      int boundary [8] = '{55, 56, 57, 63, 64, 65, 119, 120};

      restart_digest();

      // Empty message, with the ignored byte field set on the end marker.
      queue_item(KIND_END, 8'hFF, 1'b1);
      queue_item(KIND_BYTE, 8'h61, 1'b0);
      queue_item(KIND_BYTE, 8'h62, 1'b0);
      queue_item(KIND_BYTE, 8'h63, 1'b0);
      queue_item(KIND_END, 8'h00, 1'b0);
      queue_item(KIND_BYTE, 8'h00, 1'b0);
      queue_item(KIND_END, 8'h00, 1'b0);
      queue_item(KIND_BYTE, 8'hFF, 1'b0);
      queue_item(KIND_END, 8'h5A, 1'b0);
      queue_item(KIND_BYTE, 8'h55, 1'b0);
      queue_item(KIND_BYTE, 8'hAA, 1'b0);
      queue_item(KIND_END, 8'hA5, 1'b0);

      // Mostly short messages, with lengths around the padding and block edges mixed in.
      while (items_total < 410) begin
         case ($urandom_range(0, 3))
            0, 1: len = $urandom_range(0, 20);
            2: len = boundary[$urandom_range(0, 7)];
            default: len = $urandom_range(0, 130);
         endcase
         queue_random_message(len, items_total == 12 || $urandom_range(0, 9) == 0);
      end

      reset = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (items_accepted < items_total) begin
         @(posedge clock);
      end
      wait_cycles = 0;
      while (digest_expect_q.size() != 0 && wait_cycles < 20000) begin
         @(posedge clock);
         wait_cycles++;
      end
      if (digest_expect_q.size() != 0) begin
         $error("%0d expected digest words never arrived", digest_expect_q.size());
         error_count++;
      end
      repeat (300) @(posedge clock);

      $display("Hashed %0d messages totaling %0d bytes, including empty and boundary lengths.",
               messages_done, bytes_sent);
      $display("Compared %0d digest words with %0d errors.", words_checked, error_count);
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #(12 * 400000);
      $error("Run did not complete within the time limit.");
      $display("TEST FAILED");
      $finish;
   end

endmodule
